### sv/assert_macros.svh
// Assertion macros shared by the profiler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is high.
`define AHP_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("address_hit_profiler: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define AHP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("address_hit_profiler: assertion failed");

`else

`define AHP_ASSERT_SAME(name, clk, rst, ante, cons)
`define AHP_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

### sv/ahp_pkg.sv
// Shared constants, codes and types of the address hit profiler.
`timescale 1ns / 1ps
`default_nettype none

package ahp_pkg;

   // Counter store geometry.
   localparam int COUNTER_DEPTH = 4096;
   localparam int IDX_W         = $clog2(COUNTER_DEPTH);
   localparam int SIZE_W        = $clog2(COUNTER_DEPTH + 1);

   // Field widths.
   localparam int ADDR_W      = 32;
   localparam int COUNT_W     = 64;
   localparam int FUNC_W      = 2;
   localparam int WANT_W      = 7;
   localparam int NZ_W        = 13;
   localparam int SHIFT_W     = 2;
   localparam int ENTRIES_W   = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam int MAX_REPORT = 64;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_W-1:0] ALL_ONES = '1;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_HIT    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRIES = 2'd2;

   // Register reset values and limits.
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 2'd2;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 2'd2;
   localparam int ENTRIES_RESET = (4096 > COUNTER_DEPTH) ? COUNTER_DEPTH : 4096;

   // Effective configuration, already clamped.
   typedef struct packed {
      logic [ADDR_W-1:0]  base_address;
      logic [SHIFT_W-1:0] step_shift;
      logic [SIZE_W-1:0]  entries;
   } cfg_type;

   // One classified request waiting for the back end.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] address;
      logic [IDX_W-1:0]  index;
      logic              in_range;
      logic [WANT_W-1:0] report_count;
   } cmd_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
      logic              valid;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   // Counter memory access from the back end.
   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   waddr;
      logic [COUNT_W-1:0] wdata;
      logic               re;
      logic [IDX_W-1:0]   raddr;
   } ram_req_type;

   // One response item.
   typedef struct packed {
      logic [ADDR_W-1:0]  entry_address;
      logic [COUNT_W-1:0] hit_count;
      logic               entry_valid;
      logic [NZ_W-1:0]    nonzero_entries;
      logic [COUNT_W-1:0] total_hits;
      logic               last_item;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HIT_WR,
      ST_READ_OUT,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_DECIDE,
      ST_FLUSH
   } back_state_type;

endpackage

`default_nettype wire

### sv/ahp_ifs.sv
// Request, response and register-write channel interfaces of the profiler.
`timescale 1ns / 1ps
`default_nettype none

interface ahp_req_if;
   import ahp_pkg::*;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ADDR_W-1:0] address;
   logic [WANT_W-1:0] report_count;

   modport source (output valid, func, address, report_count, input ready);
   modport sink (input valid, func, address, report_count, output ready);
endinterface

interface ahp_rsp_if;
   import ahp_pkg::*;
   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  entry_address;
   logic [COUNT_W-1:0] hit_count;
   logic               entry_valid;
   logic [NZ_W-1:0]    nonzero_entries;
   logic [COUNT_W-1:0] total_hits;
   logic               last_item;

   modport source (output valid, entry_address, hit_count, entry_valid, nonzero_entries,
                   total_hits, last_item, input ready);
   modport sink (input valid, entry_address, hit_count, entry_valid, nonzero_entries,
                 total_hits, last_item, output ready);
endinterface

interface ahp_csr_if;
   import ahp_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/ahp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ahp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port; data holds until the next enabled read.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

### sv/ahp_front.sv
// Front end: accepts requests, maps the address to a counter index and queues the command.
`timescale 1ns / 1ps
`default_nettype none

module ahp_front (
   ahp_req_if.sink                         req,
   input  wire ahp_pkg::cfg_type           cfg,
   input  wire ahp_pkg::back_status_type   back_status,
   input  wire ahp_pkg::queue_status_type  q_status,
   output logic                            push,
   output ahp_pkg::cmd_type                push_cmd
);
   import ahp_pkg::*;

   logic [ADDR_W-1:0] offset;
   logic [ADDR_W-1:0] idx_full;

   // Requests wait while the counters are being cleared or the queue is full.
   assign req.ready = !back_status.clearing && !q_status.full;

   // Unknown function codes are accepted and dropped.
   assign push = req.valid && req.ready && (req.func inside {FUNC_HIT, FUNC_READ, FUNC_REPORT});

   // Address to counter index and range check.
   always_comb begin
      offset   = req.address - cfg.base_address;
      idx_full = offset >> cfg.step_shift;

      push_cmd.func     = req.func;
      push_cmd.address  = req.address;
      push_cmd.index    = idx_full[IDX_W-1:0];
      push_cmd.in_range = idx_full < ADDR_W'(cfg.entries);
      push_cmd.report_count = (req.report_count > WANT_W'(MAX_REPORT)) ?
                              WANT_W'(MAX_REPORT) : req.report_count;
   end

endmodule

`default_nettype wire

### sv/ahp_queue.sv
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module ahp_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire ahp_pkg::cmd_type            push_cmd,
   input  wire logic                        pop,
   output ahp_pkg::cmd_type                 head,
   output ahp_pkg::queue_status_type        status
);
   import ahp_pkg::*;

   cmd_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign status.count = count_ff;
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);
   assign head         = slots_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### sv/ahp_back.sv
// Back end: clears the counters, executes hits and reads, and runs top-n report scans.
`timescale 1ns / 1ps
`default_nettype none

module ahp_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ahp_pkg::cfg_type            cfg,
   input  wire ahp_pkg::cmd_type            q_head,
   input  wire ahp_pkg::queue_status_type   q_status,
   output logic                             q_pop,
   output ahp_pkg::ram_req_type             ram_req,
   input  wire logic [ahp_pkg::COUNT_W-1:0] ram_rdata,
   output ahp_pkg::back_status_type         status,
   ahp_rsp_if.source                        rsp
);
   import ahp_pkg::*;

   back_state_type      state_ff, state_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic                pipe_vld_ff;
   logic                out_vld_ff, out_vld_in;

   cmd_type             cur_ff;
   logic [IDX_W-1:0]    scan_ff;
   logic [IDX_W-1:0]    pipe_idx_ff;
   logic                first_ff;
   logic [COUNT_W-1:0]  best_val_ff;
   logic [IDX_W-1:0]    best_idx_ff;
   logic [SIZE_W-1:0]   nz_ff;
   logic [COUNT_W-1:0]  tot_ff;
   logic                pend_vld_ff;
   logic [COUNT_W-1:0]  pend_val_ff;
   logic [IDX_W-1:0]    pend_idx_ff;
   logic [WANT_W-1:0]   picks_ff;
   rsp_item_type        out_ff;

   logic                out_free;
   logic                scan_last;
   logic                got;
   logic                cand;
   logic                start_report;
   logic                scan_issue;
   logic                decide_take;
   logic                emit;
   rsp_item_type        emit_item;
   rsp_item_type        pend_item;
   rsp_item_type        empty_item;
   logic [COUNT_W-1:0]  inc_value;

   assign status.clearing = (state_ff == ST_CLEAR);
   assign out_free  = !out_vld_ff || rsp.ready;
   assign scan_last = (SIZE_W'(scan_ff) == cfg.entries - SIZE_W'(1));
   assign got       = (best_val_ff != '0) && (cur_ff.report_count != '0);
   assign inc_value = (ram_rdata == ALL_ONES) ? ram_rdata : ram_rdata + COUNT_W'(1);

   // Candidate test for the entry returning from the memory during a scan.
   assign cand = (ram_rdata != ALL_ONES) && (ram_rdata != '0) &&
                 (first_ff || (ram_rdata < pend_val_ff) ||
                  ((ram_rdata == pend_val_ff) && (pipe_idx_ff > pend_idx_ff))) &&
                 (ram_rdata > best_val_ff);

   // Response items built from the pending pick and for an empty report.
   always_comb begin
      pend_item.entry_address   = (ADDR_W'(pend_idx_ff) << cfg.step_shift) + cfg.base_address;
      pend_item.hit_count       = pend_val_ff;
      pend_item.entry_valid     = 1'b1;
      pend_item.nonzero_entries = NZ_W'(nz_ff);
      pend_item.total_hits      = tot_ff;
      pend_item.last_item       = 1'b0;

      empty_item.entry_address   = '0;
      empty_item.hit_count       = '0;
      empty_item.entry_valid     = 1'b0;
      empty_item.nonzero_entries = NZ_W'(nz_ff);
      empty_item.total_hits      = tot_ff;
      empty_item.last_item       = 1'b1;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == IDX_W'(COUNTER_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_status.valid) begin
               case (q_head.func)
                  FUNC_HIT: state_in = q_head.in_range ? ST_HIT_WR : ST_IDLE;
                  FUNC_READ: state_in = ST_READ_OUT;
                  FUNC_REPORT: state_in = (cfg.entries == '0) ? ST_DECIDE : ST_SCAN;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_HIT_WR: state_in = ST_IDLE;
         ST_READ_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_SCAN_WAIT;
            end
         end
         ST_SCAN_WAIT: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (out_free) begin
               if (!got) begin
                  state_in = ST_IDLE;
               end else if (picks_ff + WANT_W'(1) == cur_ff.report_count) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // State outputs: memory access, queue pop and response emission.
   always_comb begin
      ram_req.we    = 1'b0;
      ram_req.waddr = cur_ff.index;
      ram_req.wdata = inc_value;
      ram_req.re    = 1'b0;
      ram_req.raddr = q_head.index;
      q_pop         = 1'b0;
      start_report  = 1'b0;
      scan_issue    = 1'b0;
      decide_take   = 1'b0;
      emit          = 1'b0;
      emit_item     = empty_item;
      case (state_ff)
         ST_CLEAR: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = clr_ff;
            ram_req.wdata = '0;
         end
         ST_IDLE: begin
            if (q_status.valid) begin
               q_pop = 1'b1;
               if ((q_head.func == FUNC_HIT || q_head.func == FUNC_READ) && q_head.in_range)
               begin
                  ram_req.re = 1'b1;
               end
               if (q_head.func == FUNC_REPORT) begin
                  start_report = 1'b1;
               end
            end
         end
         ST_HIT_WR: begin
            ram_req.we = 1'b1;
         end
         ST_READ_OUT: begin
            emit = out_free;
            emit_item.entry_address   = cur_ff.address;
            emit_item.hit_count       = cur_ff.in_range ? ram_rdata : '0;
            emit_item.entry_valid     = cur_ff.in_range;
            emit_item.nonzero_entries = '0;
            emit_item.total_hits      = '0;
            emit_item.last_item       = 1'b1;
         end
         ST_SCAN: begin
            ram_req.re    = 1'b1;
            ram_req.raddr = scan_ff;
            scan_issue    = 1'b1;
         end
         ST_SCAN_WAIT: begin
         end
         ST_DECIDE: begin
            if (out_free) begin
               decide_take = got;
               if (!got) begin
                  emit = 1'b1;
                  if (pend_vld_ff) begin
                     emit_item = pend_item;
                     emit_item.last_item = 1'b1;
                  end
               end else if (pend_vld_ff) begin
                  emit      = 1'b1;
                  emit_item = pend_item;
               end
            end
         end
         ST_FLUSH: begin
            emit      = out_free;
            emit_item = pend_item;
            emit_item.last_item = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_comb begin
      clr_in     = (state_ff == ST_CLEAR) ? clr_ff + IDX_W'(1) : '0;
      out_vld_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         pipe_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         pipe_vld_ff <= scan_issue;
         out_vld_ff  <= out_vld_in;
      end
   end

   // Command, scan and pick registers.
   always_ff @(posedge clock) begin
      pipe_idx_ff <= scan_ff;
      if (q_pop) begin
         cur_ff <= q_head;
      end
      if (start_report) begin
         scan_ff     <= '0;
         first_ff    <= 1'b1;
         best_val_ff <= '0;
         best_idx_ff <= '0;
         nz_ff       <= '0;
         tot_ff      <= '0;
         pend_vld_ff <= 1'b0;
         picks_ff    <= '0;
      end else begin
         if (scan_issue) begin
            scan_ff <= scan_ff + IDX_W'(1);
         end
         // The first pass also counts nonzero entries and sums them.
         if (pipe_vld_ff) begin
            if (first_ff && ram_rdata != '0) begin
               nz_ff  <= nz_ff + SIZE_W'(1);
               tot_ff <= tot_ff + ram_rdata;
            end
            if (cand) begin
               best_val_ff <= ram_rdata;
               best_idx_ff <= pipe_idx_ff;
            end
         end
         // A new pick becomes pending and bounds the next pass.
         if (decide_take) begin
            pend_vld_ff <= 1'b1;
            pend_val_ff <= best_val_ff;
            pend_idx_ff <= best_idx_ff;
            picks_ff    <= picks_ff + WANT_W'(1);
            scan_ff     <= '0;
            first_ff    <= 1'b0;
            best_val_ff <= '0;
         end
      end
      if (emit) begin
         out_ff <= emit_item;
      end
   end

   // Response channel.
   assign rsp.valid           = out_vld_ff;
   assign rsp.entry_address   = out_ff.entry_address;
   assign rsp.hit_count       = out_ff.hit_count;
   assign rsp.entry_valid     = out_ff.entry_valid;
   assign rsp.nonzero_entries = out_ff.nonzero_entries;
   assign rsp.total_hits      = out_ff.total_hits;
   assign rsp.last_item       = out_ff.last_item;

endmodule

`default_nettype wire

### sv/address_hit_profiler_top.sv
// Top level of the address hit profiler: registers, front end, queue, back end and counter RAM.
//
// Usage: requests arrive on req_bus (func, address, report_count) and are taken when
// valid and ready are high together. A hit adds one to the 64-bit counter of the address,
// saturating at all ones, and returns nothing. A read returns one response with the count.
// A report returns up to report_count responses in descending count order, each carrying
// the nonzero-entry count and the wrapping total; last_item marks the final response.
// Registers must be written on csr_bus (index, data) only while the block is idle; the block
// does not enforce this and is always ready. A hit occupies the back end for one counter RAM
// read, issued as it leaves the queue, and one write in ST_HIT_WR. A read's response passes
// through the queue, the RAM read register and the output register before it is valid.
// A report makes one pass over the entries in use per pick, plus a closing pass when fewer
// than report_count entries qualify. Each pass reads the entries in order through the single
// read port of the counter RAM, then waits in ST_SCAN_WAIT and decides in ST_DECIDE.
// A two-entry queue lets the front end keep accepting requests while the back end works.
// After reset the counters are cleared one entry a cycle, all 4096 of them, during which
// no request is accepted. Responses sit in an output register; when the receiver stalls,
// the back end waits and the queue then fills and holds requests off.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module address_hit_profiler_top (
   input wire logic   clock,
   input wire logic   reset,
   ahp_req_if.sink    req_bus,
   ahp_rsp_if.source  rsp_bus,
   ahp_csr_if.sink    csr_bus
);
   import ahp_pkg::*;

   logic [ADDR_W-1:0]  base_ff;
   logic [SHIFT_W-1:0] shift_ff;
   logic [SIZE_W-1:0]  entries_ff;
   cfg_type            cfg;

   logic               push;
   cmd_type            push_cmd;
   logic               q_pop;
   cmd_type            q_head;
   queue_status_type   q_status;
   back_status_type    back_status;
   ram_req_type        ram_req;
   logic [COUNT_W-1:0] ram_rdata;
   logic [ENTRIES_W-1:0] entries_wr;

   // Register writes are always taken; values are stored already clamped.
   assign csr_bus.ready = 1'b1;
   assign entries_wr    = csr_bus.data[ENTRIES_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         shift_ff   <= SHIFT_RESET;
         entries_ff <= SIZE_W'(ENTRIES_RESET);
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_BASE: base_ff <= csr_bus.data[ADDR_W-1:0];
            CSR_SHIFT: begin
               shift_ff <= (csr_bus.data[SHIFT_W-1:0] > SHIFT_MAX) ?
                           '0 : csr_bus.data[SHIFT_W-1:0];
            end
            CSR_ENTRIES: begin
               entries_ff <= (int'(entries_wr) > COUNTER_DEPTH) ?
                             SIZE_W'(COUNTER_DEPTH) : SIZE_W'(entries_wr);
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.base_address = base_ff;
   assign cfg.step_shift   = shift_ff;
   assign cfg.entries      = entries_ff;

   ahp_front u_front (
      .req         (req_bus),
      .cfg         (cfg),
      .back_status (back_status),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   ahp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   ahp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_head    (q_head),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata),
      .status    (back_status),
      .rsp       (rsp_bus)
   );

   ahp_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (COUNTER_DEPTH)
   ) u_counters (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

   // No request is taken while the counters are being cleared.
   `AHP_ASSERT_SAME(a_no_accept_in_clear, clock, reset, back_status.clearing, !(req_bus.valid && req_bus.ready))

   // The queue never holds more than its depth.
   `AHP_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, q_status.count <= QCNT_W'(QUEUE_DEPTH))

   // A response without an entry carries a zero count.
   `AHP_ASSERT_SAME(a_empty_zero, clock, reset, rsp_bus.valid && !rsp_bus.entry_valid, rsp_bus.hit_count == '0)

   // A stride write never leaves the unused stride code in the register.
   `AHP_ASSERT_NEXT(a_shift_clamped, clock, reset, csr_bus.valid && csr_bus.index == CSR_SHIFT, shift_ff <= SHIFT_MAX)

endmodule

`default_nettype wire

### dv/ahp_profile_checker.sv
// Checker for the address hit profiler: tracks counters and registers, predicts and compares responses.
`timescale 1ns / 1ps

module ahp_profile_checker (
   input wire logic clock,
   input wire logic reset,
   ahp_req_if       req_mon,
   ahp_rsp_if       rsp_mon,
   ahp_csr_if       csr_mon,
   output int       failures,
   output int       outstanding
);
   import ahp_pkg::*;

   // Shadow copy of the counter store and the register file.
   logic [COUNT_W-1:0]   hit_counts [COUNTER_DEPTH];
   logic [ADDR_W-1:0]    base_q;
   logic [SHIFT_W-1:0]   shift_q;
   logic [ENTRIES_W-1:0] entries_q;

   // Responses still owed by the block, oldest first.
   rsp_item_type due_responses[$];
   rsp_item_type oldest;

   // Works out the responses of one request and updates the shadow counters.
   task automatic compute_responses(input logic [FUNC_W-1:0] func,
                                    input logic [ADDR_W-1:0] address,
                                    input logic [WANT_W-1:0] report_count);
      int unsigned        sh, size, idx, limit, picks, nz, best_idx, prev_idx, i;
      logic [ADDR_W-1:0]  offset;
      logic [COUNT_W-1:0] total, best, prev_val;
      bit                 in_range, first, have_held;
      rsp_item_type       item, held;

      sh = (shift_q <= SHIFT_MAX) ? shift_q : 0;
      size = (entries_q > COUNTER_DEPTH) ? COUNTER_DEPTH : entries_q;
      offset = address - base_q;
      idx = offset >> sh;
      in_range = (idx < size);
      item = '0;

      case (func)
         FUNC_HIT: begin
            if (in_range && hit_counts[idx] != ALL_ONES)
               hit_counts[idx] = hit_counts[idx] + 1;
         end
         FUNC_READ: begin
            item.entry_address = address;
            item.hit_count = in_range ? hit_counts[idx] : '0;
            item.entry_valid = in_range;
            item.last_item = 1'b1;
            due_responses.push_back(item);
         end
         FUNC_REPORT: begin
            limit = (report_count > MAX_REPORT) ? MAX_REPORT : report_count;
            nz = 0;
            total = '0;
            for (i = 0; i < size; i++) begin
               if (hit_counts[i] != 0) begin
                  nz++;
                  total = total + hit_counts[i];
               end
            end

            // Each pick is the largest count strictly ranked after the previous pick.
            picks = 0;
            first = 1'b1;
            prev_val = '0;
            prev_idx = 0;
            have_held = 1'b0;
            held = '0;
            while (picks < limit) begin
               best = '0;
               best_idx = 0;
               for (i = 0; i < size; i++) begin
                  if (hit_counts[i] == ALL_ONES || hit_counts[i] == 0)
                     continue;
                  if (!first && !(hit_counts[i] < prev_val ||
                                  (hit_counts[i] == prev_val && i > prev_idx)))
                     continue;
                  if (hit_counts[i] > best) begin
                     best = hit_counts[i];
                     best_idx = i;
                  end
               end
               if (best == 0)
                  break;
               prev_val = best;
               prev_idx = best_idx;
               first = 1'b0;
               if (have_held)
                  due_responses.push_back(held);
               held = '0;
               held.entry_address = ADDR_W'(best_idx << sh) + base_q;
               held.hit_count = best;
               held.entry_valid = 1'b1;
               held.nonzero_entries = NZ_W'(nz);
               held.total_hits = total;
               have_held = 1'b1;
               picks++;
            end

            // The final pick closes the report; with no pick an empty item does.
            if (!have_held) begin
               held.nonzero_entries = NZ_W'(nz);
               held.total_hits = total;
            end
            held.last_item = 1'b1;
            due_responses.push_back(held);
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [COUNT_W-1:0] expected,
                              input logic [COUNT_W-1:0] actual);
      if (expected !== actual) begin
         failures++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, expected, actual);
      end
   endtask

   // Everything is sampled at the rising edge, responses ahead of new requests.
   always @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < COUNTER_DEPTH; n++)
            hit_counts[n] = '0;
         base_q = '0;
         shift_q = SHIFT_RESET;
         entries_q = ENTRIES_W'(ENTRIES_RESET);
         due_responses.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_responses.size() == 0) begin
               failures++;
               $display("%0t: unexpected response: expected none, actual address %0h count %0h",
                        $time, rsp_mon.entry_address, rsp_mon.hit_count);
            end else begin
               oldest = due_responses.pop_front();
               check_field("entry_address", oldest.entry_address, rsp_mon.entry_address);
               check_field("hit_count", oldest.hit_count, rsp_mon.hit_count);
               check_field("entry_valid", oldest.entry_valid, rsp_mon.entry_valid);
               check_field("nonzero_entries", oldest.nonzero_entries, rsp_mon.nonzero_entries);
               check_field("total_hits", oldest.total_hits, rsp_mon.total_hits);
               check_field("last_item", oldest.last_item, rsp_mon.last_item);
            end
         end

         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_BASE:    base_q = csr_mon.data;
               CSR_SHIFT:   shift_q = csr_mon.data[SHIFT_W-1:0];
               CSR_ENTRIES: entries_q = csr_mon.data[ENTRIES_W-1:0];
               default: begin
               end
            endcase
         end

         if (req_mon.valid && req_mon.ready)
            compute_responses(req_mon.func, req_mon.address, req_mon.report_count);
      end
      outstanding = due_responses.size();
   end

endmodule

### dv/testbench.sv
// Top of the profiler testbench: clock, reset, request and register stimulus, and the verdict.
`timescale 1ns / 1ps

module testbench;
   import ahp_pkg::*;

   localparam logic [FUNC_W-1:0]      FUNC_UNUSED  = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED   = 2'd3;
   localparam int                     LIMIT_CYCLES = 10000000;
   localparam int                     IDLE_SETTLE  = 16;

   logic clock;
   logic reset;
   int   failures;
   int   outstanding;
   int   cycles;
   bit   calm;
   int   stall_left;

   // Stimulus-side copy of the registers, used to aim addresses into the region.
   logic [ADDR_W-1:0]    cur_base;
   logic [SHIFT_W-1:0]   cur_shift;
   logic [ENTRIES_W-1:0] cur_entries;

   ahp_req_if req_bus ();
   ahp_rsp_if rsp_bus ();
   ahp_csr_if csr_bus ();

   address_hit_profiler_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   ahp_profile_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_mon     (csr_bus),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Response backpressure in short random bursts, none in the calm stretch.
   initial begin
      rsp_bus.ready = 1'b1;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready = 1'b0;
            stall_left = $urandom_range(1, 4) - 1;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // Presents one request from a falling edge until it is taken.
   task automatic issue_request(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] address,
                                input logic [WANT_W-1:0] report_count);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.func = func;
      req_bus.address = address;
      req_bus.report_count = report_count;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid = 1'b1;
      csr_bus.index = index;
      csr_bus.data = value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
      case (index)
         CSR_BASE:    cur_base = value;
         CSR_SHIFT:   cur_shift = value[SHIFT_W-1:0];
         CSR_ENTRIES: cur_entries = value[ENTRIES_W-1:0];
         default: begin
         end
      endcase
   endtask

   // Stops sending and waits until every response owed has arrived and hits have settled.
   task automatic wait_idle();
      req_bus.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (IDLE_SETTLE) @(negedge clock);
   endtask

   // Mostly hot entries of the region, sometimes its far end, its boundary or anywhere.
   function automatic logic [ADDR_W-1:0] pick_address();
      int unsigned sh, size, idx, roll;
      sh = (cur_shift <= SHIFT_MAX) ? cur_shift : 0;
      size = (cur_entries > COUNTER_DEPTH) ? COUNTER_DEPTH : cur_entries;
      roll = $urandom_range(0, 9);
      if (size == 0 || roll < 2)
         return $urandom();
      if (roll == 2)
         return cur_base + ADDR_W'(size << sh);
      if (roll < 7)
         idx = $urandom_range(0, ((size < 8) ? size : 8) - 1);
      else
         idx = $urandom_range(0, size - 1);
      return cur_base + ADDR_W'(idx << sh) + ADDR_W'($urandom() & ((32'd1 << sh) - 1));
   endfunction

   // One register setting followed by a random mix of requests.
   task automatic random_phase(input logic [ADDR_W-1:0] base, input logic [SHIFT_W-1:0] shift,
                               input logic [ENTRIES_W-1:0] entries, input int count,
                               input int max_want, input bit pause_midway);
      int                k, roll;
      logic [FUNC_W-1:0] func;
      logic [WANT_W-1:0] want;
      wait_idle();
      write_register(CSR_BASE, base);
      write_register(CSR_SHIFT, 32'(shift));
      write_register(CSR_ENTRIES, 32'(entries));
      for (k = 0; k < count; k++) begin
         if (pause_midway && k == count / 2)
            wait_idle();
         roll = $urandom_range(0, 99);
         if (roll < 55)
            func = FUNC_HIT;
         else if (roll < 75)
            func = FUNC_READ;
         else if (roll < 93)
            func = FUNC_REPORT;
         else
            func = FUNC_UNUSED;
         want = WANT_W'($urandom_range(0, max_want));
         issue_request(func, pick_address(), want);
      end
   endtask

   initial begin
      reset = 1'b1;
      calm = 1'b0;
      cycles = 0;
      cur_base = '0;
      cur_shift = SHIFT_RESET;
      cur_entries = ENTRIES_W'(ENTRIES_RESET);
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_HIT;
      req_bus.address = '0;
      req_bus.report_count = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_BASE;
      csr_bus.data = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset setting: word stride over all 4096 entries.
      issue_request(FUNC_REPORT, 32'h0, 7'd5);
      issue_request(FUNC_READ, 32'h0, 7'd0);
      issue_request(FUNC_HIT, 32'h0, 7'd0);
      issue_request(FUNC_HIT, 32'h3, 7'd0);
      issue_request(FUNC_HIT, 32'h3ffc, 7'd0);
      issue_request(FUNC_HIT, 32'h4000, 7'd0);
      issue_request(FUNC_HIT, 32'hffff_ffff, 7'd127);
      issue_request(FUNC_HIT, 32'h8, 7'd0);
      issue_request(FUNC_HIT, 32'h9, 7'd0);
      issue_request(FUNC_READ, 32'h3ffc, 7'd0);
      issue_request(FUNC_READ, 32'h4000, 7'd0);
      issue_request(FUNC_READ, 32'hffff_ffff, 7'd0);
      issue_request(FUNC_UNUSED, 32'hffff_ffff, 7'd127);
      issue_request(FUNC_REPORT, 32'h0, 7'd0);
      issue_request(FUNC_REPORT, 32'h0, 7'd1);
      issue_request(FUNC_REPORT, 32'hffff_ffff, 7'd127);
      issue_request(FUNC_HIT, 32'h4, 7'd0);
      issue_request(FUNC_REPORT, 32'h0, 7'd2);

      // A write to the unassigned register index must change nothing.
      wait_idle();
      write_register(CSR_UNUSED, 32'hffff_ffff);
      issue_request(FUNC_READ, 32'h8, 7'd0);

      // Single-entry region at the top of the address space, byte stride.
      random_phase(32'hffff_fff0, 2'd0, 13'd1, 20, 3, 1'b0);
      // Halfword region that wraps past address zero, with a full drain midway.
      random_phase(32'hffff_ffe0, 2'd1, 13'd37, 40, 127, 1'b1);
      // Unused stride code, which falls back to byte stride.
      random_phase($urandom(), 2'd3, 13'd16, 30, 20, 1'b0);
      // Empty region: every address is out of range.
      random_phase(32'h0000_1000, 2'd2, 13'd0, 10, 127, 1'b0);
      // Oversized region clamps to the whole store; reports kept short since each pass is long.
      random_phase(32'h8000_0000, 2'd2, 13'h1fff, 20, 3, 1'b0);
      // Final stretch at full rate on both sides.
      wait_idle();
      calm = 1'b1;
      random_phase(32'h0000_0100, 2'd1, 13'd64, 70, 127, 1'b0);

      wait_idle();
      if (failures == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
